/* sv/assert_macros.svh */
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

/* sv/xenc_pkg.sv */
// Types and encoding constants for the x86-64 instruction byte encoder.
package xenc_pkg;

  localparam int unsigned MaxBytes = 10;
  localparam int unsigned LenW     = 4;

  typedef enum logic [3:0] {
    FN_RET     = 4'd0,
    FN_MOVABS  = 4'd1,
    FN_MOV_IMM = 4'd2,
    FN_MOV_REG = 4'd3,
    FN_INC     = 4'd4,
    FN_DEC     = 4'd5,
    FN_ADDB    = 4'd6,
    FN_SUBB    = 4'd7,
    FN_ADD     = 4'd8,
    FN_SUB     = 4'd9,
    FN_PUSH    = 4'd10,
    FN_POP     = 4'd11,
    FN_CMPB    = 4'd12,
    FN_JNZ     = 4'd13,
    FN_JZ      = 4'd14,
    FN_CALL    = 4'd15
  } func_e;

  // Prefixes
  localparam logic [7:0] REX_W  = 8'h48;
  localparam logic [7:0] REX_WB = 8'h49;
  localparam logic [7:0] REX_B  = 8'h41;

  // Opcodes
  localparam logic [7:0] OP_RET     = 8'hC3;
  localparam logic [7:0] OP_MOVABS  = 8'hB8;
  localparam logic [7:0] OP_MOV_IMM = 8'hC7;
  localparam logic [7:0] OP_MOV_RR  = 8'h89;
  localparam logic [7:0] OP_GRP5    = 8'hFF;
  localparam logic [7:0] OP_GRP1_B  = 8'h80;
  localparam logic [7:0] OP_GRP1    = 8'h81;
  localparam logic [7:0] OP_ADD_RAX = 8'h05;
  localparam logic [7:0] OP_SUB_RAX = 8'h2D;
  localparam logic [7:0] OP_ESC     = 8'h0F;
  localparam logic [7:0] OP_JNZ     = 8'h85;
  localparam logic [7:0] OP_JZ      = 8'h84;
  localparam logic [7:0] OP_PUSH    = 8'h50;
  localparam logic [7:0] OP_POP     = 8'h58;

  // ModRM bases, low three bits free for the register
  localparam logic [7:0] MR_REG_0 = 8'hC0;
  localparam logic [7:0] MR_REG_1 = 8'hC8;
  localparam logic [7:0] MR_REG_2 = 8'hD0;
  localparam logic [7:0] MR_REG_5 = 8'hE8;
  localparam logic [7:0] MR_MEM_0 = 8'h40;
  localparam logic [7:0] MR_MEM_5 = 8'h68;
  localparam logic [7:0] MR_MEM_7 = 8'h78;

  typedef logic [MaxBytes-1:0][7:0] byte_vec_t;

  // One instruction, bytes packed from index 0 in emission order
  typedef struct packed {
    byte_vec_t       bytes;
    logic [LenW-1:0] len;
  } desc_t;

endpackage

/* sv/xenc_front.sv */
// Front end: classify a request and pack its instruction bytes.
module xenc_front (
  input  logic [3:0]     func_i,
  input  logic [3:0]     target_reg_i,
  input  logic [3:0]     source_reg_i,
  input  logic [63:0]    immediate_i,
  output xenc_pkg::desc_t desc_o
);

  xenc_pkg::byte_vec_t     body;
  logic [xenc_pkg::LenW-1:0] body_len;
  logic                    add_rex_b;
  logic [7:0]              rex_w;
  logic [7:0]              lo;
  logic [7:0]              src_lo;

  always_comb begin
    rex_w     = target_reg_i[3] ? xenc_pkg::REX_WB : xenc_pkg::REX_W;
    lo        = {5'd0, target_reg_i[2:0]};
    src_lo    = {2'd0, source_reg_i[2:0], 3'd0};
    body      = '0;
    body_len  = 4'd1;
    add_rex_b = 1'b0;
    unique case (xenc_pkg::func_e'(func_i))
      xenc_pkg::FN_RET: begin
        body[0]  = xenc_pkg::OP_RET;
        body_len = 4'd1;
      end
      xenc_pkg::FN_MOVABS: begin
        body[0]   = rex_w;
        body[1]   = xenc_pkg::OP_MOVABS + lo;
        body[9:2] = immediate_i;
        body_len  = 4'd10;
      end
      xenc_pkg::FN_MOV_IMM: begin
        body[0]   = rex_w;
        body[1]   = xenc_pkg::OP_MOV_IMM;
        body[2]   = xenc_pkg::MR_REG_0 + lo;
        body[6:3] = immediate_i[31:0];
        body_len  = 4'd7;
      end
      xenc_pkg::FN_MOV_REG: begin
        body[0]  = xenc_pkg::REX_W | {5'd0, source_reg_i[3], 1'b0, target_reg_i[3]};
        body[1]  = xenc_pkg::OP_MOV_RR;
        body[2]  = xenc_pkg::MR_REG_0 | src_lo | lo;
        body_len = 4'd3;
      end
      xenc_pkg::FN_INC, xenc_pkg::FN_DEC: begin
        body[0]  = rex_w;
        body[1]  = xenc_pkg::OP_GRP5;
        body[2]  = ((func_i == xenc_pkg::FN_INC) ? xenc_pkg::MR_REG_0
                                                  : xenc_pkg::MR_REG_1) + lo;
        body_len = 4'd3;
      end
      xenc_pkg::FN_ADDB, xenc_pkg::FN_SUBB, xenc_pkg::FN_CMPB: begin
        add_rex_b = target_reg_i[3];
        body[0]   = xenc_pkg::OP_GRP1_B;
        priority case (xenc_pkg::func_e'(func_i))
          xenc_pkg::FN_ADDB: body[1] = xenc_pkg::MR_MEM_0 + lo;
          xenc_pkg::FN_SUBB: body[1] = xenc_pkg::MR_MEM_5 + lo;
          default:           body[1] = xenc_pkg::MR_MEM_7 + lo;
        endcase
        body[2]   = 8'h00;
        body[3]   = immediate_i[7:0];
        body_len  = 4'd4;
      end
      xenc_pkg::FN_ADD, xenc_pkg::FN_SUB: begin
        if (target_reg_i == 4'd0) begin
          // short accumulator form
          body[0]   = xenc_pkg::REX_W;
          body[1]   = (func_i == xenc_pkg::FN_ADD) ? xenc_pkg::OP_ADD_RAX
                                                    : xenc_pkg::OP_SUB_RAX;
          body[5:2] = immediate_i[31:0];
          body_len  = 4'd6;
        end else begin
          body[0]   = rex_w;
          body[1]   = xenc_pkg::OP_GRP1;
          body[2]   = ((func_i == xenc_pkg::FN_ADD) ? xenc_pkg::MR_REG_0
                                                     : xenc_pkg::MR_REG_5) + lo;
          body[6:3] = immediate_i[31:0];
          body_len  = 4'd7;
        end
      end
      xenc_pkg::FN_PUSH, xenc_pkg::FN_POP: begin
        add_rex_b = target_reg_i[3];
        body[0]   = ((func_i == xenc_pkg::FN_PUSH) ? xenc_pkg::OP_PUSH
                                                    : xenc_pkg::OP_POP) + lo;
        body_len  = 4'd1;
      end
      xenc_pkg::FN_JNZ, xenc_pkg::FN_JZ: begin
        body[0]   = xenc_pkg::OP_ESC;
        body[1]   = (func_i == xenc_pkg::FN_JNZ) ? xenc_pkg::OP_JNZ : xenc_pkg::OP_JZ;
        body[5:2] = immediate_i[31:0];
        body_len  = 4'd6;
      end
      xenc_pkg::FN_CALL: begin
        add_rex_b = target_reg_i[3];
        body[0]   = xenc_pkg::OP_GRP5;
        body[1]   = xenc_pkg::MR_REG_2 + lo;
        body_len  = 4'd2;
      end
    endcase

    // prepend REX.B for the short forms on r8-r15
    if (add_rex_b) begin
      desc_o.bytes = {body[xenc_pkg::MaxBytes-2:0], xenc_pkg::REX_B};
      desc_o.len   = body_len + 4'd1;
    end else begin
      desc_o.bytes = body;
      desc_o.len   = body_len;
    end
  end

endmodule

/* sv/xenc_fifo.sv */
// Short descriptor queue between the front end and the byte emitter.
module xenc_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  xenc_pkg::desc_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output xenc_pkg::desc_t rdata_o,
  output logic            empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);

  xenc_pkg::desc_t     mem_q [Depth];
  logic [AddrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* sv/xenc_back.sv */
// Back end: shift one byte per cycle into the result register unless it stalls.
module xenc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  xenc_pkg::desc_t desc_i,
  input  logic            desc_empty_i,
  output logic            desc_pop_o,
  output logic [7:0]      code_byte_o,
  output logic            last_byte_o,
  output logic            empty_o,
  input  logic            pop_i
);

  xenc_pkg::byte_vec_t       shift_q, shift_d;
  logic [xenc_pkg::LenW-1:0] rem_q, rem_d;
  logic                      busy_q, busy_d;
  logic                      out_valid_q, out_valid_d;
  logic [7:0]                out_byte_q, out_byte_d;
  logic                      out_last_q, out_last_d;
  logic                      out_free, take;

  assign out_free   = !out_valid_q || pop_i;
  assign take       = out_free && !busy_q && !desc_empty_i;
  assign desc_pop_o = take;

  always_comb begin
    shift_d     = shift_q;
    rem_d       = rem_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (out_free && busy_q) begin
      // advance within the current instruction
      out_valid_d = 1'b1;
      out_byte_d  = shift_q[0];
      out_last_d  = (rem_q == 4'd1);
      shift_d     = shift_q >> 8;
      rem_d       = rem_q - 4'd1;
      busy_d      = (rem_q != 4'd1);
    end else if (take) begin
      out_valid_d = 1'b1;
      out_byte_d  = desc_i.bytes[0];
      out_last_d  = (desc_i.len == 4'd1);
      shift_d     = desc_i.bytes >> 8;
      rem_d       = desc_i.len - 4'd1;
      busy_d      = (desc_i.len != 4'd1);
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q    <= shift_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign code_byte_o = out_byte_q;
  assign last_byte_o = out_last_q;
  assign empty_o     = !out_valid_q;

endmodule

/* sv/x86_64_instruction_byte_encoder_unit.sv */
// Top level of the x86-64 instruction byte encoder.
//
//  channel   direction  handshake       payload
//  request   in         push_i/full_o   func_i, target_reg_i, source_reg_i, immediate_i
//  bytes     out        pop_i/empty_o   code_byte_o, last_byte_o
//
// An instruction of N bytes (1 to 10) leaves at one byte per cycle while the
// output is not stalled, set by the single byte shifter in the back end.
// On an idle encoder a request is written into the descriptor queue, then its first byte into the output register.
// Requests keep entering the descriptor queue, until it fills, while bytes stall on the output.
// Reset empties the queue and the output register and idles the back-end shifter.
module x86_64_instruction_byte_encoder_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [3:0]  func_i,
  input  logic [3:0]  target_reg_i,
  input  logic [3:0]  source_reg_i,
  input  logic [63:0] immediate_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [7:0]  code_byte_o,
  output logic        last_byte_o
);

  xenc_pkg::desc_t front_desc, queue_desc;
  logic            queue_empty, queue_pop;

  xenc_front u_front (
    .func_i       (func_i),
    .target_reg_i (target_reg_i),
    .source_reg_i (source_reg_i),
    .immediate_i  (immediate_i),
    .desc_o       (front_desc)
  );

  xenc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (front_desc),
    .full_o  (full_o),
    .pop_i   (queue_pop),
    .rdata_o (queue_desc),
    .empty_o (queue_empty)
  );

  xenc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_i       (queue_desc),
    .desc_empty_i (queue_empty),
    .desc_pop_o   (queue_pop),
    .code_byte_o  (code_byte_o),
    .last_byte_o  (last_byte_o),
    .empty_o      (empty_o),
    .pop_i        (pop_i)
  );

endmodule

/* sv/xenc_checker.sv */
// Port-level checker for the instruction byte encoder, bound to the top level.
`include "assert_macros.svh"

module xenc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push_i,
  input logic        full_o,
  input logic [3:0]  func_i,
  input logic        empty_o,
  input logic        pop_i,
  input logic [7:0]  code_byte_o,
  input logic        last_byte_o
);

  logic       in_xfer, out_last_xfer;
  logic [3:0] open_q;

  assign in_xfer       = push_i && !full_o;
  assign out_last_xfer = pop_i && !empty_o && last_byte_o;

  // count instructions accepted but not yet fully delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (in_xfer && !out_last_xfer) begin
      open_q <= open_q + 4'd1;
    end else if (out_last_xfer && !in_xfer) begin
      open_q <= open_q - 4'd1;
    end
  end

  `ASSERT_CLK(a_stall_hold, !empty_o && !pop_i |=> !empty_o && $stable(code_byte_o) && $stable(last_byte_o), "stalled byte changed")
  `ASSERT_NEVER(a_no_phantom, !empty_o && open_q == 4'd0, "byte shown with no instruction open")
  `ASSERT_CLK(a_first_byte, in_xfer && open_q == 4'd0 |-> ##2 !empty_o, "first byte late on idle encoder")
  `ASSERT_CLK(a_ret_byte, in_xfer && open_q == 4'd0 && func_i == xenc_pkg::FN_RET |-> ##2 code_byte_o == xenc_pkg::OP_RET && last_byte_o, "ret encoded wrong")

endmodule

bind x86_64_instruction_byte_encoder_unit xenc_checker u_xenc_checker (.*);

/* tb/sv/x86_64_instruction_byte_encoder_unit_tb.sv */
// Self-checking testbench for the x86-64 instruction byte encoder unit.
module x86_64_instruction_byte_encoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumDirRows  = 25;
  localparam int unsigned NumRandReqs = 450;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 20;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } code_byte_t;

  // Directed request; n_bytes != 0 means the byte string in enc is typed in,
  // written in emission order from the most significant end.
  typedef struct packed {
    xenc_pkg::func_e fn;
    logic [3:0]      tr;
    logic [3:0]      sr;
    logic [63:0]     imm;
    logic [3:0]      n_bytes;
    logic [79:0]     enc;
  } dir_row_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        push_i       = 1'b0;
  logic        full_o;
  logic [3:0]  func_i       = '0;
  logic [3:0]  target_reg_i = '0;
  logic [3:0]  source_reg_i = '0;
  logic [63:0] immediate_i  = '0;
  logic        empty_o;
  logic        pop_i        = 1'b0;
  logic [7:0]  code_byte_o;
  logic        last_byte_o;

  code_byte_t  pending_bytes_q [$];
  code_byte_t  head_byte;
  int unsigned mismatch_cnt = 0;
  int unsigned stall_cnt    = 0;
  bit          quiet        = 1'b0;
  bit          hold_req     = 1'b0;

  dir_row_t dir_rows [NumDirRows] = '{
    '{xenc_pkg::FN_RET, 4'd0, 4'd0, 64'd0, 4'd1, 80'hC3},
    '{xenc_pkg::FN_RET, 4'd15, 4'd15, '1, 4'd1, 80'hC3},
    '{xenc_pkg::FN_PUSH, 4'd0, 4'd0, 64'd0, 4'd1, 80'h50},
    '{xenc_pkg::FN_PUSH, 4'd15, 4'd0, 64'd0, 4'd2, 80'h41_57},
    '{xenc_pkg::FN_POP, 4'd0, 4'd15, '1, 4'd1, 80'h58},
    '{xenc_pkg::FN_POP, 4'd15, 4'd0, 64'd0, 4'd2, 80'h41_5F},
    '{xenc_pkg::FN_MOVABS, 4'd0, 4'd0, 64'd0, 4'd10, 80'h48_B8_0000_0000_0000_0000},
    '{xenc_pkg::FN_MOVABS, 4'd15, 4'd0, '1, 4'd10, 80'h49_BF_FFFF_FFFF_FFFF_FFFF},
    '{xenc_pkg::FN_MOV_REG, 4'd0, 4'd0, 64'd0, 4'd3, 80'h48_89_C0},
    '{xenc_pkg::FN_MOV_REG, 4'd15, 4'd15, 64'd0, 4'd3, 80'h4D_89_FF},
    '{xenc_pkg::FN_MOV_REG, 4'd3, 4'd12, '1, 4'd0, 80'h0},
    '{xenc_pkg::FN_MOV_IMM, 4'd8, 4'd0, 64'h0123_4567_8000_0000, 4'd0, 80'h0},
    '{xenc_pkg::FN_INC, 4'd12, 4'd0, 64'd0, 4'd0, 80'h0},
    '{xenc_pkg::FN_DEC, 4'd4, 4'd0, 64'd0, 4'd0, 80'h0},
    '{xenc_pkg::FN_ADDB, 4'd12, 4'd0, 64'hFF, 4'd0, 80'h0},
    '{xenc_pkg::FN_SUBB, 4'd4, 4'd0, 64'hA5A5_A5A5_A5A5_A501, 4'd0, 80'h0},
    '{xenc_pkg::FN_CMPB, 4'd13, 4'd0, 64'h7F, 4'd0, 80'h0},
    '{xenc_pkg::FN_ADD, 4'd0, 4'd0, 64'hDEAD_BEEF_1234_5678, 4'd0, 80'h0},
    '{xenc_pkg::FN_ADD, 4'd8, 4'd0, 64'hFFFF_FFFF, 4'd0, 80'h0},
    '{xenc_pkg::FN_SUB, 4'd0, 4'd0, 64'h8000_0000, 4'd0, 80'h0},
    '{xenc_pkg::FN_SUB, 4'd15, 4'd0, 64'h1, 4'd0, 80'h0},
    '{xenc_pkg::FN_JNZ, 4'd0, 4'd0, 64'hFFFF_FFFF_8000_0000, 4'd0, 80'h0},
    '{xenc_pkg::FN_JZ, 4'd7, 4'd5, 64'h0000_0000_7FFF_FFFF, 4'd0, 80'h0},
    '{xenc_pkg::FN_CALL, 4'd0, 4'd0, 64'd0, 4'd0, 80'h0},
    '{xenc_pkg::FN_CALL, 4'd15, 4'd0, 64'd0, 4'd0, 80'h0}
  };

  x86_64_instruction_byte_encoder_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_o       (full_o),
    .func_i       (func_i),
    .target_reg_i (target_reg_i),
    .source_reg_i (source_reg_i),
    .immediate_i  (immediate_i),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .code_byte_o  (code_byte_o),
    .last_byte_o  (last_byte_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Append one byte at the tail of a byte string.
  function automatic void append_byte(ref logic [7:0] enc [$], input logic [7:0] b);
    enc.insert(enc.size(), b);
  endfunction

  // Machine-code bytes of one request, in emission order.
  function automatic void encode_instr(input xenc_pkg::func_e fn, input logic [3:0] tr,
                                       input logic [3:0] sr, input logic [63:0] imm,
                                       ref logic [7:0] enc [$]);
    logic [7:0] rex_wide;
    logic [7:0] lo;
    int         n_imm;
    rex_wide = tr[3] ? xenc_pkg::REX_WB : xenc_pkg::REX_W;
    lo       = {5'd0, tr[2:0]};
    n_imm    = 0;
    case (fn)
      xenc_pkg::FN_RET: append_byte(enc, xenc_pkg::OP_RET);
      xenc_pkg::FN_MOVABS: begin
        append_byte(enc, rex_wide);
        append_byte(enc, xenc_pkg::OP_MOVABS + lo);
        n_imm = 8;
      end
      xenc_pkg::FN_MOV_IMM: begin
        append_byte(enc, rex_wide);
        append_byte(enc, xenc_pkg::OP_MOV_IMM);
        append_byte(enc, xenc_pkg::MR_REG_0 + lo);
        n_imm = 4;
      end
      xenc_pkg::FN_MOV_REG: begin
        append_byte(enc, xenc_pkg::REX_W | {5'd0, sr[3], 1'b0, tr[3]});
        append_byte(enc, xenc_pkg::OP_MOV_RR);
        append_byte(enc, {2'b11, sr[2:0], tr[2:0]});
      end
      xenc_pkg::FN_INC, xenc_pkg::FN_DEC: begin
        append_byte(enc, rex_wide);
        append_byte(enc, xenc_pkg::OP_GRP5);
        append_byte(enc, (fn == xenc_pkg::FN_INC ? xenc_pkg::MR_REG_0
                                                 : xenc_pkg::MR_REG_1) + lo);
      end
      xenc_pkg::FN_ADDB, xenc_pkg::FN_SUBB, xenc_pkg::FN_CMPB: begin
        if (tr[3]) append_byte(enc, xenc_pkg::REX_B);
        append_byte(enc, xenc_pkg::OP_GRP1_B);
        case (fn)
          xenc_pkg::FN_ADDB: append_byte(enc, xenc_pkg::MR_MEM_0 + lo);
          xenc_pkg::FN_SUBB: append_byte(enc, xenc_pkg::MR_MEM_5 + lo);
          default:           append_byte(enc, xenc_pkg::MR_MEM_7 + lo);
        endcase
        append_byte(enc, 8'h00);
        n_imm = 1;
      end
      xenc_pkg::FN_ADD, xenc_pkg::FN_SUB: begin
        // rax alone takes the short accumulator form
        if (tr == 4'd0) begin
          append_byte(enc, xenc_pkg::REX_W);
          append_byte(enc, fn == xenc_pkg::FN_ADD ? xenc_pkg::OP_ADD_RAX
                                                  : xenc_pkg::OP_SUB_RAX);
        end else begin
          append_byte(enc, rex_wide);
          append_byte(enc, xenc_pkg::OP_GRP1);
          append_byte(enc, (fn == xenc_pkg::FN_ADD ? xenc_pkg::MR_REG_0
                                                   : xenc_pkg::MR_REG_5) + lo);
        end
        n_imm = 4;
      end
      xenc_pkg::FN_PUSH, xenc_pkg::FN_POP: begin
        if (tr[3]) append_byte(enc, xenc_pkg::REX_B);
        append_byte(enc, (fn == xenc_pkg::FN_PUSH ? xenc_pkg::OP_PUSH
                                                  : xenc_pkg::OP_POP) + lo);
      end
      xenc_pkg::FN_JNZ, xenc_pkg::FN_JZ: begin
        append_byte(enc, xenc_pkg::OP_ESC);
        append_byte(enc, fn == xenc_pkg::FN_JNZ ? xenc_pkg::OP_JNZ : xenc_pkg::OP_JZ);
        n_imm = 4;
      end
      default: begin
        if (tr[3]) append_byte(enc, xenc_pkg::REX_B);
        append_byte(enc, xenc_pkg::OP_GRP5);
        append_byte(enc, xenc_pkg::MR_REG_2 + lo);
      end
    endcase
    for (int i = 0; i < n_imm; i++) append_byte(enc, imm[8*i +: 8]);
  endfunction

  task automatic send_req(input xenc_pkg::func_e fn, input logic [3:0] tr,
                          input logic [3:0] sr, input logic [63:0] imm,
                          input logic [3:0] n_bytes, input logic [79:0] typed);
    logic [7:0] enc [$];
    int         n;
    code_byte_t item;
    n = n_bytes;
    // Idle with noise on the payload
    if (!quiet && $urandom_range(99) < 22) begin
      push_i       <= 1'b0;
      func_i       <= 4'($urandom);
      target_reg_i <= 4'($urandom);
      source_reg_i <= 4'($urandom);
      immediate_i  <= {$urandom, $urandom};
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    push_i       <= 1'b1;
    func_i       <= fn;
    target_reg_i <= tr;
    source_reg_i <= sr;
    immediate_i  <= imm;
    do @(posedge clk_i); while (full_o);
    if (n != 0) begin
      for (int k = 0; k < n; k++) append_byte(enc, typed[8*(n-1-k) +: 8]);
    end else begin
      encode_instr(fn, tr, sr, imm, enc);
    end
    foreach (enc[k]) begin
      item.code = enc[k];
      item.last = (k == enc.size() - 1);
      pending_bytes_q.insert(pending_bytes_q.size(), item);
    end
    @(negedge clk_i);
  endtask

  task automatic send_random_req();
    logic [63:0] imm;
    case ($urandom_range(7))
      0:       imm = '0;
      1:       imm = '1;
      2:       imm = {32'd0, $urandom};
      3:       imm = {$urandom, 32'hFFFF_FFFF};
      default: imm = {$urandom, $urandom};
    endcase
    send_req(xenc_pkg::func_e'($urandom_range(15)), 4'($urandom), 4'($urandom), imm,
             4'd0, 80'h0);
  endtask

  // Receiver: random pops, or a long hold-off on request.
  initial begin
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        pop_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else begin
        pop_i <= quiet || ($urandom_range(99) >= 22);
      end
    end
  end

  // Check each byte transfer against the oldest pending expectation.
  always @(posedge clk_i) begin
    if (rst_ni && pop_i && !empty_o) begin
      if (pending_bytes_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected byte, expected none, actual code %02h last %0b",
                 $time, code_byte_o, last_byte_o);
      end else begin
        head_byte = pending_bytes_q.pop_front();
        if (code_byte_o !== head_byte.code) begin
          mismatch_cnt++;
          $display("%0t: code_byte expected %02h actual %02h",
                   $time, head_byte.code, code_byte_o);
        end
        if (last_byte_o !== head_byte.last) begin
          mismatch_cnt++;
          $display("%0t: last_byte expected %0b actual %0b",
                   $time, head_byte.last, last_byte_o);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push_i && !full_o) || (pop_i && !empty_o)) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, StallLimit);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i])
      send_req(dir_rows[i].fn, dir_rows[i].tr, dir_rows[i].sr, dir_rows[i].imm,
               dir_rows[i].n_bytes, dir_rows[i].enc);

    for (int i = 0; i < NumRandReqs; i++) begin
      if (i == 150) begin
        // Pause until every pending byte has drained, then stall the output
        push_i <= 1'b0;
        while (pending_bytes_q.size() != 0) @(negedge clk_i);
        hold_req = 1'b1;
      end
      quiet = (i >= 220 && i < 320);
      send_random_req();
    end
    push_i <= 1'b0;
    quiet = 1'b0;

    while (pending_bytes_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/xenc_pkg.sv
sv/xenc_front.sv
sv/xenc_fifo.sv
sv/xenc_back.sv
sv/x86_64_instruction_byte_encoder_unit.sv
sv/xenc_checker.sv
tb/sv/x86_64_instruction_byte_encoder_unit_tb.sv
